>>> hw/rtl/kbt_pkg.sv
package kbt_pkg;

   // Field widths of the channel words
   localparam int VALUE_W     = 32;
   localparam int COEF_W      = 32;
   localparam int INDEX_W     = 10;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 1;

   // Product of a Q16.16 value and a Q8.24 weight, and the sum of two of them
   localparam int PROD_W     = VALUE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int FRAC_SHIFT = 24;
   localparam int RND_W      = ACC_W - FRAC_SHIFT;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = 65'sd8388608;
   localparam logic [COEF_W-1:0]       COEF_RESET = 32'h0100_0000;

   typedef logic [OPCODE_W-1:0] opcode_type;
   localparam opcode_type OP_WRITE = 2'd0;
   localparam opcode_type OP_RUN   = 2'd1;
   localparam opcode_type OP_READ  = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_COEF_SAME  = 1'd0;
   localparam csr_index_type REG_COEF_CROSS = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_DATA,
      ST_XF_LO,
      ST_XF_HI,
      ST_XF_CAP,
      ST_XF_M1,
      ST_XF_M2,
      ST_XF_M3,
      ST_XF_M4,
      ST_XF_M5,
      ST_XF_WLO,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      ADDR_REQ,
      ADDR_LO,
      ADDR_HI
   } addr_sel_type;

   typedef enum logic [1:0] {
      MUL_HI_SAME,
      MUL_LO_CROSS,
      MUL_HI_CROSS,
      MUL_LO_SAME
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic         host_latch;
      logic         sticky_clr;
      logic         ram_rd;
      logic         ram_wr;
      addr_sel_type addr_sel;
      logic         cap_lo;
      logic         cap_hi;
      mul_sel_type  mul_sel;
      acc_op_type   acc_op;
      logic         walk_clear;
      logic         walk_step;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
   } status_type;

endpackage

>>> hw/rtl/kbt_if.sv
interface kbt_req_if;
   import kbt_pkg::*;

   logic                      valid;
   logic                      ready;
   opcode_type                opcode;
   logic [INDEX_W-1:0]        elem_index;
   logic signed [VALUE_W-1:0] elem_value;

   modport source (output valid, opcode, elem_index, elem_value, input ready);
   modport sink   (input valid, opcode, elem_index, elem_value, output ready);
endinterface

interface kbt_rsp_if;
   import kbt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic [INDEX_W-1:0]        out_index;
   logic                      sat_seen;

   modport source (output valid, out_value, out_index, sat_seen, input ready);
   modport sink   (input valid, out_value, out_index, sat_seen, output ready);
endinterface

interface kbt_csr_if;
   import kbt_pkg::*;

   logic               valid;
   logic               ready;
   csr_index_type      reg_index;
   logic [COEF_W-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> hw/rtl/kbt_ram.sv
module kbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/kbt_ctrl.sv
module kbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  kbt_pkg::opcode_type req_opcode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kbt_pkg::status_type status,
   output kbt_pkg::cmd_type    cmd
);
   import kbt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.host_latch = 1'b1;
               unique case (req_opcode)
                  OP_WRITE: begin
                     cmd.ram_wr     = 1'b1;
                     cmd.addr_sel   = ADDR_REQ;
                     cmd.sticky_clr = 1'b1;
                     state_in       = ST_RESP;
                  end
                  OP_RUN: begin
                     cmd.walk_clear = 1'b1;
                     state_in       = ST_XF_LO;
                  end
                  OP_READ: begin
                     cmd.ram_rd   = 1'b1;
                     cmd.addr_sel = ADDR_REQ;
                     state_in     = ST_RD_DATA;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_RD_DATA: begin
            cmd.cap_lo = 1'b1;
            state_in   = ST_RESP;
         end
         ST_XF_LO: begin
            cmd.ram_rd   = 1'b1;
            cmd.addr_sel = ADDR_LO;
            state_in     = ST_XF_HI;
         end
         ST_XF_HI: begin
            cmd.ram_rd   = 1'b1;
            cmd.addr_sel = ADDR_HI;
            cmd.cap_lo   = 1'b1;
            state_in     = ST_XF_CAP;
         end
         ST_XF_CAP: begin
            cmd.cap_hi = 1'b1;
            state_in   = ST_XF_M1;
         end
         ST_XF_M1: begin
            cmd.mul_sel = MUL_HI_SAME;
            state_in    = ST_XF_M2;
         end
         ST_XF_M2: begin
            cmd.mul_sel = MUL_LO_CROSS;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_XF_M3;
         end
         ST_XF_M3: begin
            cmd.mul_sel = MUL_HI_CROSS;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_XF_M4;
         end
         ST_XF_M4: begin
            cmd.ram_wr   = 1'b1;
            cmd.addr_sel = ADDR_HI;
            cmd.mul_sel  = MUL_LO_SAME;
            cmd.acc_op   = ACC_LOAD;
            state_in     = ST_XF_M5;
         end
         ST_XF_M5: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_XF_WLO;
         end
         ST_XF_WLO: begin
            cmd.ram_wr    = 1'b1;
            cmd.addr_sel  = ADDR_LO;
            cmd.walk_step = 1'b1;
            state_in      = status.walk_last ? ST_RESP : ST_XF_LO;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign req_ready    = (state_ff == ST_IDLE);

endmodule

>>> hw/rtl/kbt_datapath.sv
module kbt_datapath #(
   parameter int LOG_LENGTH = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kbt_pkg::cmd_type                   cmd,
   output kbt_pkg::status_type                status,
   input  kbt_pkg::opcode_type                req_opcode,
   input  logic [kbt_pkg::INDEX_W-1:0]        req_elem_index,
   input  logic signed [kbt_pkg::VALUE_W-1:0] req_elem_value,
   input  logic                               csr_valid,
   input  kbt_pkg::csr_index_type             csr_reg_index,
   input  logic [kbt_pkg::COEF_W-1:0]         csr_wr_data,
   output logic signed [kbt_pkg::VALUE_W-1:0] out_value,
   output logic [kbt_pkg::INDEX_W-1:0]        out_index,
   output logic                               sat_seen
);
   import kbt_pkg::*;

   localparam int ADDR_W  = LOG_LENGTH;
   localparam int STAGE_W = $clog2(LOG_LENGTH + 1);
   localparam logic [ADDR_W-1:0]  LAST_PAIR  = ADDR_W'((1 << (LOG_LENGTH - 1)) - 1);
   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(LOG_LENGTH - 1);

   logic [COEF_W-1:0]         coef_same_ff, coef_same_in;
   logic [COEF_W-1:0]         coef_cross_ff, coef_cross_in;
   logic                      sticky_ff, sticky_in;
   logic [STAGE_W-1:0]        stage_ff, stage_in;
   logic [ADDR_W-1:0]         pair_ff, pair_in;
   logic signed [VALUE_W-1:0] lo_ff, lo_in;
   logic signed [VALUE_W-1:0] hi_ff, hi_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   opcode_type                op_ff, op_in;
   logic [INDEX_W-1:0]        index_ff, index_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [INDEX_W-1:0]        out_index_ff, out_index_in;
   logic                      sat_seen_ff, sat_seen_in;

   logic [INDEX_W+ADDR_W-1:0] req_index_ext;
   logic [ADDR_W-1:0]         low_mask;
   logic [ADDR_W-1:0]         lo_addr;
   logic [ADDR_W-1:0]         hi_addr;
   logic [ADDR_W-1:0]         ram_addr;
   logic [VALUE_W-1:0]        ram_wdata;
   logic [VALUE_W-1:0]        ram_rdata;
   logic                      last_pair;

   logic signed [VALUE_W-1:0] mul_a;
   logic [COEF_W-1:0]         mul_c;
   logic signed [PROD_W:0]    prod_full;
   logic signed [ACC_W-1:0]   round_sum;
   logic signed [ACC_W-1:0]   round_shift;
   logic signed [RND_W-1:0]   rnd;
   logic                      sat_hi;
   logic                      sat_lo;
   logic [VALUE_W-1:0]        sat_result;

   // Pair addresses: insert a zero (lo) or a one (hi) at the stage bit
   assign req_index_ext = {{ADDR_W{1'b0}}, req_elem_index};
   assign low_mask      = (ADDR_W'(1) << stage_ff) - ADDR_W'(1);
   assign lo_addr       = ((pair_ff & ~low_mask) << 1) | (pair_ff & low_mask);
   assign hi_addr       = lo_addr | (ADDR_W'(1) << stage_ff);
   assign last_pair     = (pair_ff == LAST_PAIR);
   assign status.walk_last = last_pair && (stage_ff == LAST_STAGE);

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_REQ: ram_addr = req_index_ext[ADDR_W-1:0];
         ADDR_LO:  ram_addr = lo_addr;
         ADDR_HI:  ram_addr = hi_addr;
         default:  ram_addr = lo_addr;
      endcase
   end

   assign ram_wdata = (cmd.addr_sel == ADDR_REQ) ? req_elem_value : sat_result;

   kbt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (1 << LOG_LENGTH)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.ram_rd),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // Shared multiplier, signed value times unsigned weight
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_HI_SAME: begin
            mul_a = hi_ff;
            mul_c = coef_same_ff;
         end
         MUL_LO_CROSS: begin
            mul_a = lo_ff;
            mul_c = coef_cross_ff;
         end
         MUL_HI_CROSS: begin
            mul_a = hi_ff;
            mul_c = coef_cross_ff;
         end
         MUL_LO_SAME: begin
            mul_a = lo_ff;
            mul_c = coef_same_ff;
         end
         default: begin
            mul_a = lo_ff;
            mul_c = coef_same_ff;
         end
      endcase
   end

   assign prod_full = mul_a * $signed({1'b0, mul_c});
   assign prod_in   = $signed(prod_full[PROD_W-1:0]);

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = {prod_ff[PROD_W-1], prod_ff};
         ACC_ADD:  acc_in = acc_ff + {prod_ff[PROD_W-1], prod_ff};
         default:  acc_in = acc_ff;
      endcase
   end

   // Round half up to Q16.16, then clamp to the 32-bit range
   assign round_sum   = acc_ff + ROUND_HALF;
   assign round_shift = round_sum >>> FRAC_SHIFT;
   assign rnd         = round_shift[RND_W-1:0];
   assign sat_hi      = !rnd[RND_W-1] && (|rnd[RND_W-2:VALUE_W-1]);
   assign sat_lo      = rnd[RND_W-1] && !(&rnd[RND_W-2:VALUE_W-1]);

   always_comb begin
      if (sat_hi) begin
         sat_result = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (sat_lo) begin
         sat_result = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat_result = rnd[VALUE_W-1:0];
      end
   end

   always_comb begin
      coef_same_in  = coef_same_ff;
      coef_cross_in = coef_cross_ff;
      if (csr_valid) begin
         unique case (csr_reg_index)
            REG_COEF_SAME:  coef_same_in  = csr_wr_data;
            REG_COEF_CROSS: coef_cross_in = csr_wr_data;
         endcase
      end
   end

   always_comb begin
      if (cmd.sticky_clr) begin
         sticky_in = 1'b0;
      end else if (cmd.ram_wr && (cmd.addr_sel != ADDR_REQ) && (sat_hi || sat_lo)) begin
         sticky_in = 1'b1;
      end else begin
         sticky_in = sticky_ff;
      end
   end

   always_comb begin
      stage_in = stage_ff;
      pair_in  = pair_ff;
      if (cmd.walk_clear) begin
         stage_in = '0;
         pair_in  = '0;
      end else if (cmd.walk_step) begin
         if (last_pair) begin
            pair_in  = '0;
            stage_in = stage_ff + STAGE_W'(1);
         end else begin
            pair_in = pair_ff + ADDR_W'(1);
         end
      end
   end

   assign lo_in    = cmd.cap_lo ? $signed(ram_rdata) : lo_ff;
   assign hi_in    = cmd.cap_hi ? $signed(ram_rdata) : hi_ff;
   assign op_in    = cmd.host_latch ? req_opcode : op_ff;
   assign index_in = cmd.host_latch ? req_elem_index : index_ff;

   always_comb begin
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      sat_seen_in  = sat_seen_ff;
      if (cmd.rsp_load) begin
         out_value_in = (op_ff == OP_READ) ? lo_ff : '0;
         out_index_in = index_ff;
         sat_seen_in  = sticky_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_same_ff  <= COEF_RESET;
         coef_cross_ff <= COEF_RESET;
         sticky_ff     <= 1'b0;
         stage_ff      <= '0;
         pair_ff       <= '0;
      end else begin
         coef_same_ff  <= coef_same_in;
         coef_cross_ff <= coef_cross_in;
         sticky_ff     <= sticky_in;
         stage_ff      <= stage_in;
         pair_ff       <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      op_ff        <= op_in;
      index_ff     <= index_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      sat_seen_ff  <= sat_seen_in;
   end

   assign out_value = out_value_ff;
   assign out_index = out_index_ff;
   assign sat_seen  = sat_seen_ff;

endmodule

>>> hw/rtl/kron_2x2_butterfly_transform.sv
// Kronecker-power 2x2 butterfly transform over a vector of 2^LOG_LENGTH signed
// Q16.16 elements held in an on-chip RAM. Each request word carries an opcode:
// write stores elem_value at elem_index (masked to LOG_LENGTH bits) and clears
// the saturation flag; run applies, for every index bit from lowest to highest,
// the matrix [coef_same coef_cross; coef_cross coef_same] (unsigned Q8.24, both
// reset to 1.0) to each pair of elements differing only in that bit, rounding
// half up and saturating to 32 bits; read returns the stored element; any other
// code changes nothing. Every request yields exactly one response word carrying
// out_value (zero unless read), the echoed index and the sticky saturation flag.
// One request is handled at a time: a write goes through ST_RESP, a read through
// ST_RD_DATA and ST_RESP, a run through every pair of every stage, then ST_RESP.
// Each pair steps through ST_XF_LO to ST_XF_WLO, paced by the single RAM address
// (two reads and two writes per pair) and the one shared 32x33 multiplier that
// forms the four products in turn. A finished response waits in an output
// register, and the next request is taken while it waits. Coefficient writes are
// always accepted and must only be issued while the block is idle.
module kron_2x2_butterfly_transform #(
   parameter int LOG_LENGTH = 10
) (
   input logic       clock,
   input logic       reset,
   kbt_req_if.sink   req_ch,
   kbt_rsp_if.source rsp_ch,
   kbt_csr_if.sink   csr_ch
);
   import kbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Coefficient registers take a word on every cycle
   assign csr_ch.ready = 1'b1;

   // Sequence host operations and the pair walk
   kbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the vector, coefficients, multiply-accumulate and response payload
   kbt_datapath #(
      .LOG_LENGTH (LOG_LENGTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_ch.opcode),
      .req_elem_index (req_ch.elem_index),
      .req_elem_value (req_ch.elem_value),
      .csr_valid      (csr_ch.valid),
      .csr_reg_index  (csr_ch.reg_index),
      .csr_wr_data    (csr_ch.wr_data),
      .out_value      (rsp_ch.out_value),
      .out_index      (rsp_ch.out_index),
      .sat_seen       (rsp_ch.sat_seen)
   );

endmodule

>>> hw/rtl/kbt_checker.sv
module kbt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [kbt_pkg::VALUE_W-1:0] rsp_out_value,
   input logic [kbt_pkg::INDEX_W-1:0]        rsp_out_index,
   input logic                               rsp_sat_seen
);
   import kbt_pkg::*;

   logic armed_ff;

   always_ff @(posedge clock) begin
      armed_ff <= !reset;
   end

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      armed_ff && rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_value) && $stable(rsp_out_index)
         && $stable(rsp_sat_seen))
      else $error("response word changed while stalled");

   // One request in flight: an accepted word drops ready
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      armed_ff && req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A new response only appears at the end of a request
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      armed_ff && $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared with no request in flight");

   // Finishing a request always leaves its response word
   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      armed_ff && $rose(req_ready) |-> rsp_valid)
      else $error("request finished without a response word");

endmodule

bind kron_2x2_butterfly_transform kbt_checker u_kbt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_value (rsp_ch.out_value),
   .rsp_out_index (rsp_ch.out_index),
   .rsp_sat_seen  (rsp_ch.sat_seen)
);
